FILE: rtl/ppa_pkg.sv
`default_nettype none

package ppa_pkg;

  localparam int unsigned POOL_SIZE = 64;
  localparam int unsigned IDX_W     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int unsigned NXT_W     = $clog2(POOL_SIZE + 1);
  localparam int unsigned SUM_W     = ((IDX_W > 8) ? IDX_W : 8) + 1;

  localparam int unsigned PORT_W = 16;
  localparam int unsigned TAG_W  = 32;
  localparam int unsigned DIST_W = 8;
  localparam int unsigned KIND_W = 3;

  localparam logic [PORT_W-1:0] POOL_BASE_RST = 16'd10000;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIRST   = 3'd0,
    KIND_ROUND   = 3'd1,
    KIND_TAGGED  = 3'd2,
    KIND_ALIGNED = 3'd3,
    KIND_OFFSET  = 3'd4,
    KIND_RELEASE = 3'd5,
    KIND_LOOKUP  = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LK_RD,
    ST_LK_CMP,
    ST_RESP
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/port_pool_allocator_unit.sv
// Port pool allocator. Requests enter as beats on the input channel (in_valid_i,
// in_stall_o) and each gives exactly one result beat on the output channel
// (out_valid_o, out_stall_i). The port number of pool entry zero is written on
// its own configuration channel (cfg_valid_i, cfg_ready_o), which is always ready.
// A small sequencer steps through the pool entries one at a time, forming each
// port number as the pool base plus the entry index. First-fit, tagged, release
// and pair requests scan upward from entry zero; round-robin starts at the
// round-robin pointer and wraps to entry zero at most once; lookup reads the tag
// memory and then compares, in separate states, for each entry. A zero distance
// pair or an unused kind goes straight to the response state.
// One request is in flight at a time and the input is free again in the cycle
// after the result register loads.
// A finished result sits in the output register while the next request is
// accepted; if the receiver stalls, the sequencer holds its next result until
// the output register is free.
// Reset clears all used flags, all tags (through per-entry valid bits), the
// round-robin pointer and sets the port number of entry zero to 10000; no
// clearing pass is needed.

`default_nettype none

module port_pool_allocator_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [ppa_pkg::PORT_W-1:0]     cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [ppa_pkg::KIND_W-1:0]     kind_i,
  input  wire logic [ppa_pkg::TAG_W-1:0]      tag_address_i,
  input  wire logic [ppa_pkg::PORT_W-1:0]     port_number_i,
  input  wire logic [ppa_pkg::DIST_W-1:0]     distance_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                granted_o,
  output logic [ppa_pkg::PORT_W-1:0]          first_port_o,
  output logic [ppa_pkg::PORT_W-1:0]          second_port_o
);

  localparam int unsigned PS = ppa_pkg::POOL_SIZE;
  localparam int unsigned IW = ppa_pkg::IDX_W;
  localparam int unsigned NW = ppa_pkg::NXT_W;
  localparam int unsigned SW = ppa_pkg::SUM_W;
  localparam int unsigned PW = ppa_pkg::PORT_W;
  localparam int unsigned TW = ppa_pkg::TAG_W;
  localparam int unsigned DW = ppa_pkg::DIST_W;

  ppa_pkg::state_e state_q, state_d;
  ppa_pkg::kind_e  kind_q, kind_d;

  logic [PW-1:0] base_q;
  logic [TW-1:0] tag_q, tag_d;
  logic [PW-1:0] port_q, port_d;
  logic [DW-1:0] dist_q, dist_d;

  logic [PS-1:0] used_q, used_d;
  logic [PS-1:0] tag_vld_q, tag_vld_d;
  logic [NW-1:0] next_q, next_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          wrap_q, wrap_d;

  logic          res_grant_q, res_grant_d;
  logic [PW-1:0] res_first_q, res_first_d;
  logic [PW-1:0] res_second_q, res_second_d;

  logic          out_vld_q, out_vld_d;
  logic          out_grant_q, out_grant_d;
  logic [PW-1:0] out_first_q, out_first_d;
  logic [PW-1:0] out_second_q, out_second_d;

  logic [TW-1:0] tag_mem [PS];
  logic [TW-1:0] tag_rdata_q;
  logic          tag_we;

  logic          accept;
  logic          is_last;
  logic [PW-1:0] cur_port;
  logic [SW-1:0] pair_sum;
  logic [SW-1:0] pair_next;
  logic [IW-1:0] partner;
  logic [TW-1:0] stored_tag;

  assign cfg_ready_o   = 1'b1;
  assign in_stall_o    = (state_q != ppa_pkg::ST_IDLE);
  assign accept        = in_valid_i && !in_stall_o;
  assign out_valid_o   = out_vld_q;
  assign granted_o     = out_grant_q;
  assign first_port_o  = out_first_q;
  assign second_port_o = out_second_q;

  assign is_last    = (idx_q == IW'(PS - 1));
  assign cur_port   = base_q + PW'(idx_q);
  assign pair_sum   = SW'(idx_q) + SW'(dist_q);
  assign pair_next  = SW'(idx_q) + ((kind_q == ppa_pkg::KIND_ALIGNED) ? SW'(dist_q) : SW'(1));
  assign partner    = pair_sum[IW-1:0];
  assign stored_tag = tag_vld_q[idx_q] ? tag_rdata_q : '0;

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    tag_d        = tag_q;
    port_d       = port_q;
    dist_d       = dist_q;
    used_d       = used_q;
    tag_vld_d    = tag_vld_q;
    next_d       = next_q;
    idx_d        = idx_q;
    wrap_d       = wrap_q;
    res_grant_d  = res_grant_q;
    res_first_d  = res_first_q;
    res_second_d = res_second_q;
    out_vld_d    = out_vld_q && out_stall_i;
    out_grant_d  = out_grant_q;
    out_first_d  = out_first_q;
    out_second_d = out_second_q;
    tag_we       = 1'b0;

    case (state_q)
      ppa_pkg::ST_IDLE: begin
        if (accept) begin
          kind_d       = ppa_pkg::kind_e'(kind_i);
          tag_d        = tag_address_i;
          port_d       = port_number_i;
          dist_d       = distance_i;
          res_grant_d  = 1'b0;
          res_first_d  = '0;
          res_second_d = '0;
          idx_d        = '0;
          wrap_d       = 1'b0;
          case (ppa_pkg::kind_e'(kind_i))
            ppa_pkg::KIND_FIRST, ppa_pkg::KIND_TAGGED, ppa_pkg::KIND_RELEASE: begin
              state_d = ppa_pkg::ST_SCAN;
            end
            ppa_pkg::KIND_ROUND: begin
              state_d = ppa_pkg::ST_SCAN;
              if (next_q >= NW'(PS)) begin
                wrap_d = 1'b1;
              end else begin
                idx_d = next_q[IW-1:0];
              end
            end
            ppa_pkg::KIND_ALIGNED, ppa_pkg::KIND_OFFSET: begin
              state_d = (distance_i == '0) ? ppa_pkg::ST_RESP : ppa_pkg::ST_SCAN;
            end
            ppa_pkg::KIND_LOOKUP: begin
              state_d = ppa_pkg::ST_LK_RD;
            end
            default: begin
              state_d = ppa_pkg::ST_RESP;
            end
          endcase
        end
      end

      ppa_pkg::ST_SCAN: begin
        case (kind_q)
          ppa_pkg::KIND_FIRST, ppa_pkg::KIND_TAGGED: begin
            if (!used_q[idx_q]) begin
              used_d[idx_q] = 1'b1;
              if (kind_q == ppa_pkg::KIND_TAGGED) begin
                tag_we           = 1'b1;
                tag_vld_d[idx_q] = 1'b1;
              end
              res_grant_d = 1'b1;
              res_first_d = cur_port;
              state_d     = ppa_pkg::ST_RESP;
            end else if (is_last) begin
              state_d = ppa_pkg::ST_RESP;
            end else begin
              idx_d = idx_q + IW'(1);
            end
          end
          ppa_pkg::KIND_ROUND: begin
            if (!used_q[idx_q]) begin
              used_d[idx_q] = 1'b1;
              next_d        = NW'(idx_q) + NW'(1);
              res_grant_d   = 1'b1;
              res_first_d   = cur_port;
              state_d       = ppa_pkg::ST_RESP;
            end else if (is_last) begin
              if (wrap_q) begin
                next_d  = '0;
                state_d = ppa_pkg::ST_RESP;
              end else begin
                idx_d  = '0;
                wrap_d = 1'b1;
              end
            end else begin
              idx_d = idx_q + IW'(1);
            end
          end
          ppa_pkg::KIND_ALIGNED, ppa_pkg::KIND_OFFSET: begin
            if (pair_sum >= SW'(PS)) begin
              state_d = ppa_pkg::ST_RESP;
            end else if (!used_q[idx_q] && !used_q[partner]) begin
              used_d[idx_q]   = 1'b1;
              used_d[partner] = 1'b1;
              res_grant_d     = 1'b1;
              res_first_d     = cur_port;
              res_second_d    = base_q + PW'(partner);
              state_d         = ppa_pkg::ST_RESP;
            end else if (pair_next >= SW'(PS)) begin
              state_d = ppa_pkg::ST_RESP;
            end else begin
              idx_d = pair_next[IW-1:0];
            end
          end
          ppa_pkg::KIND_RELEASE: begin
            if (cur_port == port_q) begin
              used_d[idx_q]    = 1'b0;
              tag_vld_d[idx_q] = 1'b0;
              res_grant_d      = 1'b1;
              res_first_d      = cur_port;
              state_d          = ppa_pkg::ST_RESP;
            end else if (is_last) begin
              state_d = ppa_pkg::ST_RESP;
            end else begin
              idx_d = idx_q + IW'(1);
            end
          end
          default: begin
            state_d = ppa_pkg::ST_RESP;
          end
        endcase
      end

      ppa_pkg::ST_LK_RD: begin
        state_d = ppa_pkg::ST_LK_CMP;
      end

      ppa_pkg::ST_LK_CMP: begin
        if (stored_tag == tag_q) begin
          res_grant_d = 1'b1;
          res_first_d = cur_port;
          state_d     = ppa_pkg::ST_RESP;
        end else if (is_last) begin
          state_d = ppa_pkg::ST_RESP;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = ppa_pkg::ST_LK_RD;
        end
      end

      ppa_pkg::ST_RESP: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d    = 1'b1;
          out_grant_d  = res_grant_q;
          out_first_d  = res_first_q;
          out_second_d = res_second_q;
          state_d      = ppa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = ppa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ppa_pkg::ST_IDLE;
      base_q    <= ppa_pkg::POOL_BASE_RST;
      used_q    <= '0;
      tag_vld_q <= '0;
      next_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      tag_vld_q <= tag_vld_d;
      next_q    <= next_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        base_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    tag_q        <= tag_d;
    port_q       <= port_d;
    dist_q       <= dist_d;
    idx_q        <= idx_d;
    wrap_q       <= wrap_d;
    res_grant_q  <= res_grant_d;
    res_first_q  <= res_first_d;
    res_second_q <= res_second_d;
    out_grant_q  <= out_grant_d;
    out_first_q  <= out_first_d;
    out_second_q <= out_second_d;
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[idx_q] <= tag_q;
    end
    tag_rdata_q <= tag_mem[idx_q];
  end

endmodule

`default_nettype wire

FILE: rtl/ppa_checker.sv
`default_nettype none

module ppa_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_stall_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic                       granted_o,
  input wire logic [ppa_pkg::PORT_W-1:0] first_port_o,
  input wire logic [ppa_pkg::PORT_W-1:0] second_port_o
);

  // A stalled result beat stays on the output unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(granted_o)
      && $stable(first_port_o) && $stable(second_port_o))
    else $error("stalled result beat changed");

  // A failed request reports no ports.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !granted_o |-> first_port_o == '0 && second_port_o == '0)
    else $error("failed result carries a port");

  // Once a request is taken, no further beat is taken until it is served.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while one is in flight");

  // A new result only appears after the sequencer has been busy with it.
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a request in flight");

endmodule

bind port_pool_allocator_unit ppa_checker u_ppa_checker (.*);

`default_nettype wire
